// ----- src/ufat_pkg.sv -----
// ufat_pkg: shared types, constants and small tables for the unix-seconds to
// fat timestamp pipeline. No dependencies; imported by every module in src.
package ufat_pkg;

  // seconds per civil day
  localparam logic [16:0] SECS_PER_DAY = 17'd86400;

  // range limits in seconds: 1980-01-01 00:00:00 and 2108-01-01 00:00:00
  localparam logic [32:0] SECS_FIRST = 33'd315532800;
  localparam logic [32:0] SECS_PAST  = 33'd4354819200;

  // day index of 1600-03-01 is days + DOE_OFFSET; one era is DAYS_PER_ERA days
  localparam logic [17:0] DOE_OFFSET   = 18'd135080;
  localparam logic [17:0] DAYS_PER_ERA = 18'd146097;
  localparam logic [17:0] ERA_LAST_DAY = 18'd146096;

  // first year of the two eras that cover the fat range
  localparam logic [11:0] YEAR_ERA_LO = 12'd1600;
  localparam logic [11:0] YEAR_ERA_HI = 12'd2000;
  localparam logic [11:0] FAT_BASE_YEAR = 12'd1980;

  // reciprocals for exact constant division: ceil(2^shift / divisor)
  localparam int DAY_SHIFT = 36;
  localparam longint unsigned DAY_RECIP = ((64'd1 << DAY_SHIFT) + 64'd674) / 64'd675;
  localparam int Q1460_SHIFT = 29;
  localparam longint unsigned Q1460_RECIP = ((64'd1 << Q1460_SHIFT) + 64'd1459) / 64'd1460;
  localparam int YOE_SHIFT = 27;
  localparam longint unsigned YOE_RECIP = ((64'd1 << YOE_SHIFT) + 64'd364) / 64'd365;
  localparam int HR_SHIFT = 29;
  localparam longint unsigned HR_RECIP = ((64'd1 << HR_SHIFT) + 64'd3599) / 64'd3600;
  localparam int MN_SHIFT = 18;
  localparam longint unsigned MN_RECIP = ((64'd1 << MN_SHIFT) + 64'd59) / 64'd60;
  localparam int MP_SHIFT = 20;
  localparam longint unsigned MP_RECIP = ((64'd1 << MP_SHIFT) + 64'd152) / 64'd153;

  localparam logic [11:0] SECS_PER_HOUR = 12'd3600;
  localparam logic [5:0]  SECS_PER_MIN  = 6'd60;

  // saturated words
  localparam logic [31:0] FAT_WORD_MIN = (32'd1 << 21) | (32'd1 << 16);
  localparam logic [31:0] FAT_WORD_MAX = (32'd127 << 25) | (32'd12 << 21) |
                                         (32'd31 << 16) | (32'd23 << 11) |
                                         (32'd59 << 5) | 32'd29;

  // days split from seconds, day of era and range flags
  typedef struct packed {
    logic [16:0] tod;
    logic [17:0] doe;
    logic        era_hi;
    logic        below;
    logic        above;
  } ufat_split_t;

  // civil fields ahead of final packing
  typedef struct packed {
    logic [8:0] doy;
    logic [4:0] mp;
    logic [8:0] yoe;
    logic       era_hi;
    logic [4:0] hr;
    logic [5:0] mn;
    logic [5:0] sc;
    logic       below;
    logic       above;
  } ufat_civil_t;

  // doe / 36524 by comparison
  function automatic logic [2:0] div_36524(input logic [17:0] doe);
    logic [2:0] q;
    q = 3'd0;
    for (int k = 1; k < 8; k++) begin
      q = q + 3'(doe >= 18'(k * 36524));
    end
    return q;
  endfunction

  // yoe / 100 by comparison
  function automatic logic [2:0] div_100(input logic [8:0] yoe);
    logic [2:0] q;
    q = 3'd0;
    for (int k = 1; k < 6; k++) begin
      q = q + 3'(yoe >= 9'(k * 100));
    end
    return q;
  endfunction

  // first day of year (march based) for each month index: (153*mp+2)/5
  function automatic logic [8:0] month_start(input logic [4:0] mp);
    logic [8:0] ofs;
    case (mp)
      5'd0:    ofs = 9'd0;
      5'd1:    ofs = 9'd31;
      5'd2:    ofs = 9'd61;
      5'd3:    ofs = 9'd92;
      5'd4:    ofs = 9'd122;
      5'd5:    ofs = 9'd153;
      5'd6:    ofs = 9'd184;
      5'd7:    ofs = 9'd214;
      5'd8:    ofs = 9'd245;
      5'd9:    ofs = 9'd275;
      5'd10:   ofs = 9'd306;
      5'd11:   ofs = 9'd337;
      default: ofs = 9'd0;
    endcase
    return ofs;
  endfunction

endpackage

// ----- src/ufat_daysplit.sv -----
// ufat_daysplit: two pipeline stages that split seconds into days and time of
// day, then fold the day count into a day of the 400-year era. Uses ufat_pkg.
module ufat_daysplit
  import ufat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [32:0] in_secs,
  output logic        out_valid,
  input  logic        out_ready,
  output ufat_split_t out_data
);

  logic        s1_v_r;
  logic [32:0] s1_secs_r;
  logic [16:0] s1_days_r;
  logic        s1_below_r;
  logic        s1_above_r;
  logic        s2_v_r;
  ufat_split_t s2_data_r;

  logic        s1_adv;
  logic        s2_adv;
  logic [52:0] day_prod;
  logic [16:0] days_nxt;
  logic [32:0] tod_full;
  logic [17:0] shifted;
  logic        era_hi;
  ufat_split_t s2_nxt;

  // stage advance: a stage moves when it is empty or the next one moves
  assign s2_adv   = !s2_v_r || out_ready;
  assign s1_adv   = !s1_v_r || s2_adv;
  assign in_ready = s1_adv;

  // days = secs / 86400 as (secs >> 7) / 675 by reciprocal
  assign day_prod = 53'(in_secs[32:7]) * 53'(DAY_RECIP);
  assign days_nxt = day_prod[DAY_SHIFT+16:DAY_SHIFT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_adv) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s1_secs_r  <= in_secs;
      s1_days_r  <= days_nxt;
      s1_below_r <= (in_secs < SECS_FIRST);
      s1_above_r <= (in_secs >= SECS_PAST);
    end
  end

  // remainder of the day and day of era
  assign tod_full = s1_secs_r - 33'(s1_days_r) * 33'(SECS_PER_DAY);
  assign shifted  = 18'(s1_days_r) + DOE_OFFSET;
  assign era_hi   = (shifted >= DAYS_PER_ERA);

  always_comb begin
    s2_nxt.tod    = tod_full[16:0];
    s2_nxt.doe    = era_hi ? (shifted - DAYS_PER_ERA) : shifted;
    s2_nxt.era_hi = era_hi;
    s2_nxt.below  = s1_below_r;
    s2_nxt.above  = s1_above_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (s2_adv) begin
      s2_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_data_r <= s2_nxt;
    end
  end

  assign out_valid = s2_v_r;
  assign out_data  = s2_data_r;

endmodule

// ----- src/ufat_civil.sv -----
// ufat_civil: four pipeline stages that turn a day of era into year of era,
// day of year and month index, and time of day into hour, minute, second.
// Uses ufat_pkg.
module ufat_civil
  import ufat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  ufat_split_t in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output ufat_civil_t out_data
);

  // stage 1 registers
  logic        c1_v_r;
  logic [17:0] c1_doe_r;
  logic [7:0]  c1_q1460_r;
  logic [2:0]  c1_q36524_r;
  logic        c1_last_r;
  logic [4:0]  c1_hr_r;
  logic [16:0] c1_tod_r;
  logic        c1_era_r;
  logic        c1_below_r;
  logic        c1_above_r;
  // stage 2 registers
  logic        c2_v_r;
  logic [17:0] c2_doe_r;
  logic [8:0]  c2_yoe_r;
  logic [4:0]  c2_hr_r;
  logic [11:0] c2_mrem_r;
  logic        c2_era_r;
  logic        c2_below_r;
  logic        c2_above_r;
  // stage 3 registers
  logic        c3_v_r;
  logic [8:0]  c3_doy_r;
  logic [8:0]  c3_yoe_r;
  logic [4:0]  c3_hr_r;
  logic [11:0] c3_mrem_r;
  logic [5:0]  c3_mn_r;
  logic        c3_era_r;
  logic        c3_below_r;
  logic        c3_above_r;
  // stage 4 registers
  logic        c4_v_r;
  ufat_civil_t c4_data_r;

  logic c1_adv;
  logic c2_adv;
  logic c3_adv;
  logic c4_adv;

  logic [36:0] q1460_prod;
  logic [34:0] hr_prod;
  logic [17:0] yoe_num;
  logic [36:0] yoe_prod;
  logic [11:0] mrem_nxt;
  logic [17:0] yoe_days;
  logic [17:0] doy_full;
  logic [24:0] mn_prod;
  logic [11:0] mp_num;
  logic [24:0] mp_prod;
  logic [5:0]  sc_nxt;
  ufat_civil_t c4_nxt;

  // stage advance chain
  assign c4_adv   = !c4_v_r || out_ready;
  assign c3_adv   = !c3_v_r || c4_adv;
  assign c2_adv   = !c2_v_r || c3_adv;
  assign c1_adv   = !c1_v_r || c2_adv;
  assign in_ready = c1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      c1_v_r <= 1'b0;
      c2_v_r <= 1'b0;
      c3_v_r <= 1'b0;
      c4_v_r <= 1'b0;
    end else begin
      if (c1_adv) begin
        c1_v_r <= in_valid;
      end
      if (c2_adv) begin
        c2_v_r <= c1_v_r;
      end
      if (c3_adv) begin
        c3_v_r <= c2_v_r;
      end
      if (c4_adv) begin
        c4_v_r <= c3_v_r;
      end
    end
  end

  // stage 1: leap corrections of the era and the hour
  assign q1460_prod = 37'(in_data.doe) * 37'(Q1460_RECIP);
  assign hr_prod    = 35'(in_data.tod) * 35'(HR_RECIP);

  always_ff @(posedge clk) begin
    if (c1_adv) begin
      c1_doe_r    <= in_data.doe;
      c1_q1460_r  <= q1460_prod[Q1460_SHIFT+7:Q1460_SHIFT];
      c1_q36524_r <= div_36524(in_data.doe);
      c1_last_r   <= (in_data.doe >= ERA_LAST_DAY);
      c1_hr_r     <= hr_prod[HR_SHIFT+4:HR_SHIFT];
      c1_tod_r    <= in_data.tod;
      c1_era_r    <= in_data.era_hi;
      c1_below_r  <= in_data.below;
      c1_above_r  <= in_data.above;
    end
  end

  // stage 2: year of era and seconds within the hour
  assign yoe_num  = c1_doe_r - 18'(c1_q1460_r) + 18'(c1_q36524_r) - 18'(c1_last_r);
  assign yoe_prod = 37'(yoe_num) * 37'(YOE_RECIP);
  assign mrem_nxt = 12'(c1_tod_r - 17'(c1_hr_r) * 17'(SECS_PER_HOUR));

  always_ff @(posedge clk) begin
    if (c2_adv) begin
      c2_doe_r   <= c1_doe_r;
      c2_yoe_r   <= yoe_prod[YOE_SHIFT+8:YOE_SHIFT];
      c2_hr_r    <= c1_hr_r;
      c2_mrem_r  <= mrem_nxt;
      c2_era_r   <= c1_era_r;
      c2_below_r <= c1_below_r;
      c2_above_r <= c1_above_r;
    end
  end

  // stage 3: day of year and minute
  assign yoe_days = 18'(c2_yoe_r) * 18'd365 + 18'(c2_yoe_r[8:2]) - 18'(div_100(c2_yoe_r));
  assign doy_full = c2_doe_r - yoe_days;
  assign mn_prod  = 25'(c2_mrem_r) * 25'(MN_RECIP);

  always_ff @(posedge clk) begin
    if (c3_adv) begin
      c3_doy_r   <= doy_full[8:0];
      c3_yoe_r   <= c2_yoe_r;
      c3_hr_r    <= c2_hr_r;
      c3_mrem_r  <= c2_mrem_r;
      c3_mn_r    <= mn_prod[MN_SHIFT+5:MN_SHIFT];
      c3_era_r   <= c2_era_r;
      c3_below_r <= c2_below_r;
      c3_above_r <= c2_above_r;
    end
  end

  // stage 4: march-based month index and second
  assign mp_num  = 12'(c3_doy_r) * 12'd5 + 12'd2;
  assign mp_prod = 25'(mp_num) * 25'(MP_RECIP);
  assign sc_nxt  = 6'(c3_mrem_r - 12'(c3_mn_r) * 12'(SECS_PER_MIN));

  always_comb begin
    c4_nxt.doy    = c3_doy_r;
    c4_nxt.mp     = mp_prod[MP_SHIFT+4:MP_SHIFT];
    c4_nxt.yoe    = c3_yoe_r;
    c4_nxt.era_hi = c3_era_r;
    c4_nxt.hr     = c3_hr_r;
    c4_nxt.mn     = c3_mn_r;
    c4_nxt.sc     = sc_nxt;
    c4_nxt.below  = c3_below_r;
    c4_nxt.above  = c3_above_r;
  end

  always_ff @(posedge clk) begin
    if (c4_adv) begin
      c4_data_r <= c4_nxt;
    end
  end

  assign out_valid = c4_v_r;
  assign out_data  = c4_data_r;

endmodule

// ----- src/unix_seconds_to_fat_timestamp.sv -----
// Converts seconds since 1970-01-01 00:00:00 UTC into the 32-bit FAT date and
// time word; dates before 1980 or after 2107 saturate and raise out_of_range.
// The pipeline takes one beat per clock while the output is not stalled:
// two stages split the count into days and time of day, four stages derive
// the civil date and the clock fields by constant reciprocal multiplies, and
// a last stage packs the word. Stalls back up stage by stage, so empty stages
// still fill while the output waits. Depends on ufat_pkg, ufat_daysplit and
// ufat_civil.
module unix_seconds_to_fat_timestamp
  import ufat_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [32:0] in_unix_seconds,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_fat_timestamp,
  output logic        out_out_of_range
);

  logic        split_valid;
  logic        split_ready;
  logic        split_in_ready;
  ufat_split_t split_data;
  logic        civil_valid;
  logic        civil_ready;
  ufat_civil_t civil_data;

  logic        out_valid_r;
  logic [31:0] word_r;
  logic        range_r;

  logic [8:0]  day_full;
  logic [4:0]  day_nxt;
  logic [3:0]  mon_nxt;
  logic [11:0] year_nxt;
  logic [11:0] yoff_full;
  logic [31:0] word_nxt;
  logic        range_nxt;

  ufat_daysplit u_daysplit (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (split_in_ready),
    .in_secs   (in_unix_seconds),
    .out_valid (split_valid),
    .out_ready (split_ready),
    .out_data  (split_data)
  );

  ufat_civil u_civil (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (split_valid),
    .in_ready  (split_ready),
    .in_data   (split_data),
    .out_valid (civil_valid),
    .out_ready (civil_ready),
    .out_data  (civil_data)
  );

  assign in_stall    = !split_in_ready;
  assign civil_ready = !out_valid_r || !out_stall;

  // day of month, calendar month and year
  assign day_full  = civil_data.doy - month_start(civil_data.mp) + 9'd1;
  assign day_nxt   = day_full[4:0];
  assign mon_nxt   = (civil_data.mp < 5'd10) ? 4'(civil_data.mp + 5'd3)
                                             : 4'(civil_data.mp - 5'd9);
  assign year_nxt  = 12'(civil_data.yoe)
                   + (civil_data.era_hi ? YEAR_ERA_HI : YEAR_ERA_LO)
                   + 12'(mon_nxt <= 4'd2);
  assign yoff_full = year_nxt - FAT_BASE_YEAR;

  // pack and saturate
  always_comb begin
    range_nxt = civil_data.below || civil_data.above;
    if (civil_data.below) begin
      word_nxt = FAT_WORD_MIN;
    end else if (civil_data.above) begin
      word_nxt = FAT_WORD_MAX;
    end else begin
      word_nxt = {yoff_full[6:0], mon_nxt, day_nxt, civil_data.hr,
                  civil_data.mn, civil_data.sc[5:1]};
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (civil_ready) begin
      out_valid_r <= civil_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (civil_ready) begin
      word_r  <= word_nxt;
      range_r <= range_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fat_timestamp = word_r;
  assign out_out_of_range  = range_r;

endmodule

// ----- test/testbench.sv -----
// testbench: sends counts of unix seconds through unix_seconds_to_fat_timestamp
// and checks every fat word and range flag against a calendar predictor.
// Depends on src/ufat_pkg.sv and the rtl of the block.
module testbench;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int RANDOM_PER_PHASE = 220;
  localparam int PHASE_COUNT = 5;
  localparam int DRAIN_CYCLES = 20;
  localparam longint unsigned DAY_SECS = 86400;
  localparam longint unsigned HOUR_SECS = 3600;
  localparam longint unsigned MINUTE_SECS = 60;
  localparam longint unsigned EARLIEST_YEAR = 1980;
  localparam longint unsigned LATEST_YEAR = 2107;
  // days from 0000-03-01 to 1970-01-01, and days in a 400-year era
  localparam longint unsigned EPOCH_DAYS = 719468;
  localparam longint unsigned ERA_DAYS = 146097;
  // last day index that still fits a whole day in 33 bits of seconds
  localparam longint unsigned LAST_WHOLE_DAY = 99419;

  typedef struct packed {
    logic [31:0] word;
    logic        clamped;
  } fat_stamp_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [32:0] in_unix_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] out_fat_timestamp;
  logic        out_out_of_range;

  logic [32:0] seconds_to_send[$];
  fat_stamp_t  stamps_due[$];
  int          send_idle_pct = 0;
  int          stall_pct = 0;
  int          mismatches = 0;
  int          stamps_checked = 0;
  int          early_clamps = 0;
  int          late_clamps = 0;
  int          quiet_cycles = 0;

  unix_seconds_to_fat_timestamp DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_unix_seconds   (in_unix_seconds),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fat_timestamp (out_fat_timestamp),
    .out_out_of_range  (out_out_of_range)
  );

  // 20 time unit clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // civil date by eras of 400 years counted from march 1st, then fat packing
  function automatic fat_stamp_t fat_from_seconds(input logic [32:0] secs);
    longint unsigned days, tod, shifted, era, doe, yoe, doy, mp, dom, mon, year;
    fat_stamp_t stamp;
    days = longint'(secs) / DAY_SECS;
    tod = longint'(secs) % DAY_SECS;
    shifted = days + EPOCH_DAYS;
    era = shifted / ERA_DAYS;
    doe = shifted - era * ERA_DAYS;
    yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp = (5 * doy + 2) / 153;
    dom = doy - (153 * mp + 2) / 5 + 1;
    mon = (mp < 10) ? mp + 3 : mp - 9;
    year = yoe + era * 400 + ((mon <= 2) ? 1 : 0);
    stamp.clamped = 1'b1;
    if (year < EARLIEST_YEAR) begin
      stamp.word = {7'd0, 4'd1, 5'd1, 5'd0, 6'd0, 5'd0};
    end else if (year > LATEST_YEAR) begin
      stamp.word = {7'd127, 4'd12, 5'd31, 5'd23, 6'd59, 5'd29};
    end else begin
      stamp.clamped = 1'b0;
      stamp.word = {7'(year - EARLIEST_YEAR), 4'(mon), 5'(dom), 5'(tod / HOUR_SECS),
                    6'((tod / MINUTE_SECS) % 60), 5'((tod % MINUTE_SECS) / 2)};
    end
    return stamp;
  endfunction

  // sender: predicts each accepted beat, offers the next pending count
  always @(posedge clk) begin : drive_beats
    fat_stamp_t due;
    logic       offer;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        due = fat_from_seconds(in_unix_seconds);
        stamps_due.push_back(due);
        if (due.clamped) begin
          if (in_unix_seconds < ufat_pkg::SECS_FIRST) early_clamps++;
          else late_clamps++;
        end
      end
      if (!in_valid || !in_stall) begin
        offer = seconds_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct;
        if (offer) in_unix_seconds <= seconds_to_send.pop_front();
        in_valid <= offer;
      end
    end
  end

  // receiver: compares each result beat with the oldest stamp due
  always @(posedge clk) begin : check_beats
    fat_stamp_t want;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (stamps_due.size() == 0) begin
          $error("result beat with no stamp due: fat_timestamp %h", out_fat_timestamp);
          mismatches++;
        end else begin
          want = stamps_due.pop_front();
          stamps_checked++;
          if (out_fat_timestamp !== want.word) begin
            $error("fat_timestamp: expected %h, got %h", want.word, out_fat_timestamp);
            mismatches++;
          end
          if (out_out_of_range !== want.clamped) begin
            $error("out_of_range: expected %b, got %b", want.clamped, out_out_of_range);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // watchdog on cycles without any beat on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("watchdog: no beat for %0d cycles, %0d stamps outstanding",
                 WATCHDOG_LIMIT, stamps_due.size());
        $display("status: fail");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // hold off until every offered count has come back as a result
  task automatic wait_drained();
    while (seconds_to_send.size() != 0 || in_valid || stamps_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin : stimulus
    longint unsigned pick;
    longint unsigned edge_secs;
    int              kind;
    int              sel;
    logic [32:0]     secs;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // epoch and the last second before 1980
    seconds_to_send.push_back(33'd0);
    seconds_to_send.push_back(ufat_pkg::SECS_FIRST - 33'd1);
    // first fat second, odd seconds rounding down
    seconds_to_send.push_back(ufat_pkg::SECS_FIRST);
    seconds_to_send.push_back(ufat_pkg::SECS_FIRST + 33'd1);
    seconds_to_send.push_back(ufat_pkg::SECS_FIRST + 33'd59);
    seconds_to_send.push_back(ufat_pkg::SECS_FIRST + 33'd86399);
    // leap days: 1980, 2000 (century divisible by 400), 2024
    seconds_to_send.push_back(33'd320630400);
    seconds_to_send.push_back(33'd951782400);
    seconds_to_send.push_back(33'd1709164800);
    // turn of the century
    seconds_to_send.push_back(33'd946684799);
    seconds_to_send.push_back(33'd946684800);
    // 2100 is not a leap year
    seconds_to_send.push_back(33'd4107542399);
    seconds_to_send.push_back(33'd4107542400);
    // 31 and 32 bit boundaries
    seconds_to_send.push_back(33'd2147483647);
    seconds_to_send.push_back(33'd2147483648);
    seconds_to_send.push_back(33'd4294967295);
    seconds_to_send.push_back(33'd4294967296);
    // last fat second, first second past 2107, far beyond
    seconds_to_send.push_back(ufat_pkg::SECS_PAST - 33'd1);
    seconds_to_send.push_back(ufat_pkg::SECS_PAST);
    seconds_to_send.push_back(33'd5000000000);
    seconds_to_send.push_back(33'h1_FFFF_FFFE);
    seconds_to_send.push_back(33'h1_FFFF_FFFF);
    wait_drained();

    // random phases with different idle and stall mixes
    for (int phase = 0; phase < PHASE_COUNT; phase++) begin
      case (phase)
        1: begin send_idle_pct = 61; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 61; end
        3: begin send_idle_pct = 38; stall_pct = 38; end
        default: begin send_idle_pct = 0; stall_pct = 0; end
      endcase
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
        kind = $urandom_range(99);
        pick = {$urandom, $urandom};
        if (kind < 50) begin
          // anywhere inside the fat range
          secs = 33'(ufat_pkg::SECS_FIRST +
                     pick % (ufat_pkg::SECS_PAST - ufat_pkg::SECS_FIRST));
        end else if (kind < 65) begin
          // just after midnight or just before the next one
          sel = $urandom_range(4);
          secs = 33'((pick % (LAST_WHOLE_DAY + 1)) * DAY_SECS +
                     ((sel < 3) ? sel : DAY_SECS - 5 + sel));
        end else if (kind < 75) begin
          // straddling either end of the fat range
          edge_secs = $urandom_range(1) ? ufat_pkg::SECS_FIRST : ufat_pkg::SECS_PAST;
          secs = 33'(edge_secs + $urandom_range(200) - 100);
        end else begin
          secs = pick[32:0];
        end
        seconds_to_send.push_back(secs);
      end
      if (phase == 2) wait_drained();
      else while (seconds_to_send.size() != 0) @(negedge clk);
    end

    send_idle_pct = 0;
    stall_pct = 0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d fat words across %0d idle/stall phases", stamps_checked,
             PHASE_COUNT);
    $display("%0d saturated below 1980, %0d saturated above 2107", early_clamps,
             late_clamps);
    if (mismatches == 0 && stamps_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches, %0d stamps never returned", mismatches, stamps_due.size());
      $display("status: fail");
    end
    $finish;
  end

endmodule
